[sv/itwa_pkg.sv]
package itwa_pkg;

	// Width of the dividend and quotient of the estimate divider
	localparam int DIV_BITS = 32;

	// Window length after reset, before clamping to MAX_WINDOW
	localparam int WINDOW_RESET = 60;

	// Item kinds; codes 5 to 7 behave as a read
	typedef enum logic [2:0] {
		KIND_RECORD = 3'd0,
		KIND_START  = 3'd1,
		KIND_STOP   = 3'd2,
		KIND_LAP    = 3'd3,
		KIND_READ   = 3'd4
	} itwa_kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_APPLY,
		ST_LAST_RD,
		ST_LAST_WAIT,
		ST_ENT_RD,
		ST_ENT_DIV,
		ST_DIV_WAIT,
		ST_DONE
	} itwa_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic apply;
		logic zero_result;
		logic rd_last;
		logic take_last;
		logic est_init;
		logic rd_entry;
		logic div_start;
		logic est_step;
	} itwa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic idx_bad;
		logic div_done;
		logic est_last;
	} itwa_stat_t;

endpackage

[sv/itwa_ram.sv]
module itwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/itwa_div.sv]
module itwa_div import itwa_pkg::*; #(
	parameter int DW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DW-1:0]       divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient,
	output logic                rem_nz
);

	localparam int CW = $clog2(DIV_BITS + 1);

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign done     = run_q && (cnt_q == '0);
	assign quotient = quo_q;
	assign rem_nz   = (rem_q != '0);

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign shifted = {rem_q, quo_q[DIV_BITS-1]};
	assign fits    = (shifted >= {1'b0, divisor});

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(DIV_BITS);
		end else if (done) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Shift the quotient in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q && (cnt_q != '0)) begin
			if (fits) begin
				rem_q <= DW'(shifted - {1'b0, divisor});
			end else begin
				rem_q <= shifted[DW-1:0];
			end
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

endmodule

[sv/itwa_datapath.sv]
module itwa_datapath import itwa_pkg::*; #(
	parameter int TIMER_COUNT = 4,
	parameter int MAX_WINDOW  = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  itwa_cmd_t   cmd,
	output itwa_stat_t  stat,
	input  logic [2:0]  kind,
	input  logic [1:0]  timer_index,
	input  logic [31:0] duration_in,
	input  logic [31:0] now_stamp,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	output logic        status,
	output logic [31:0] measured,
	output logic [31:0] last_duration,
	output logic [31:0] estimate
);

	localparam int TW       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int PW       = $clog2(MAX_WINDOW);
	localparam int WLW      = $clog2(MAX_WINDOW + 1);
	localparam int DEPTH    = TIMER_COUNT * MAX_WINDOW;
	localparam int AW       = $clog2(DEPTH);
	localparam int TB       = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int WL_RESET = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	// Item fields held for the whole item
	logic [2:0]    kind_q;
	logic [1:0]    tidx_q;
	logic [31:0]   dur_q;
	logic [TB-1:0] now_q;
	logic [TW-1:0] tid;

	// Timer state
	logic [WLW-1:0]         wl_q;
	logic [PW-1:0]          pos_q [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] run_q;
	logic [TB-1:0]          stamp_q [TIMER_COUNT];

	// Sequencing and estimate state
	logic [AW-1:0] clr_cnt_q;
	logic [PW-1:0] i_q;
	logic          ge_q;
	logic          status_q;
	logic [31:0]   meas_q;
	logic [31:0]   last_q;
	logic [31:0]   e_q;

	logic [PW-1:0]  pos_cur;
	logic [WLW-1:0] pos_inc;
	logic [PW-1:0]  pos_next;
	logic [PW-1:0]  last_idx;
	logic           running;
	logic           is_stop;
	logic           is_lap;
	logic           is_start;
	logic           do_rec;
	logic [TB-1:0]  elapsed;
	logic [31:0]    meas_val;
	logic [31:0]    rec_val;
	logic [AW-1:0]  base;
	logic [AW-1:0]  pos_addr;
	logic [AW-1:0]  last_addr;
	logic [AW-1:0]  ent_addr;
	logic [WLW-1:0] cfg_clamped;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	logic [31:0]    div_dividend;
	logic [WLW-1:0] div_divisor;
	logic           div_done;
	logic [31:0]    div_quo;
	logic           div_rem_nz;

	assign tid = TW'(tidx_q);

	// Decode the held item against the addressed timer
	assign pos_cur  = pos_q[tid];
	assign running  = run_q[tid];
	assign is_stop  = (kind_q == KIND_STOP);
	assign is_lap   = (kind_q == KIND_LAP);
	assign is_start = (kind_q == KIND_START);
	assign do_rec   = (kind_q == KIND_RECORD) || ((is_stop || is_lap) && running);
	assign elapsed  = now_q - stamp_q[tid];
	assign meas_val = 32'(elapsed);
	assign rec_val  = (kind_q == KIND_RECORD) ? dur_q : meas_val;

	// Advance the write position, wrap at the window length
	assign pos_inc  = WLW'(pos_cur) + WLW'(1);
	assign pos_next = (pos_inc >= wl_q) ? '0 : PW'(pos_inc);
	assign last_idx = (pos_cur == '0) ? PW'(wl_q - WLW'(1)) : pos_cur - PW'(1);

	// Form store addresses
	assign base      = AW'(tid) * AW'(MAX_WINDOW);
	assign pos_addr  = base + AW'(pos_cur);
	assign last_addr = base + AW'(last_idx);
	assign ent_addr  = base + AW'(i_q);

	// Clamp a written window length into 1 .. MAX_WINDOW
	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = WLW'(1);
		end else if (32'(cfg_data) > MAX_WINDOW) begin
			cfg_clamped = WLW'(MAX_WINDOW);
		end else begin
			cfg_clamped = WLW'(cfg_data);
		end
	end

	// Steer the store ports
	assign ram_we    = cmd.clr_step || (cmd.apply && do_rec);
	assign ram_waddr = cmd.clr_step ? clr_cnt_q : pos_addr;
	assign ram_wdata = cmd.clr_step ? '0 : rec_val;
	assign ram_re    = cmd.rd_last || cmd.rd_entry;
	assign ram_raddr = cmd.rd_last ? last_addr : ent_addr;

	itwa_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divide the distance to the entry by its count
	assign div_dividend = (ram_rdata >= e_q) ? ram_rdata - e_q : e_q - ram_rdata;
	assign div_divisor  = WLW'(i_q) + WLW'(1);

	itwa_div #(
		.DW (WLW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	// Report status
	assign stat.clear_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign stat.idx_bad    = (32'(tidx_q) >= TIMER_COUNT);
	assign stat.div_done   = div_done;
	assign stat.est_last   = (WLW'(i_q) == (wl_q - WLW'(1)));

	// Update timer state and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q      <= WLW'(WL_RESET);
			run_q     <= '0;
			clr_cnt_q <= '0;
			i_q       <= '0;
			for (int t = 0; t < TIMER_COUNT; t++) begin
				pos_q[t]   <= '0;
				stamp_q[t] <= '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cfg_we) begin
				wl_q <= cfg_clamped;
				for (int t = 0; t < TIMER_COUNT; t++) begin
					pos_q[t] <= '0;
				end
			end else if (cmd.apply) begin
				if (do_rec) begin
					pos_q[tid] <= pos_next;
				end
				if (is_start || is_lap) begin
					run_q[tid]   <= 1'b1;
					stamp_q[tid] <= now_q;
				end else if (is_stop) begin
					run_q[tid] <= 1'b0;
				end
			end
			if (cmd.est_init) begin
				i_q <= '0;
			end else if (cmd.est_step) begin
				i_q <= i_q + PW'(1);
			end
		end
	end

	// Hold item fields and build the result word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			tidx_q <= timer_index;
			dur_q  <= duration_in;
			now_q  <= TB'(now_stamp);
		end
		if (cmd.zero_result) begin
			status_q <= 1'b0;
			meas_q   <= '0;
			last_q   <= '0;
			e_q      <= '0;
		end else begin
			if (cmd.apply) begin
				status_q <= is_stop && !running;
				meas_q   <= ((is_stop || is_lap) && running) ? meas_val : '0;
			end
			if (cmd.take_last) begin
				last_q <= ram_rdata;
			end
			if (cmd.est_init) begin
				e_q <= '0;
			end else if (cmd.est_step) begin
				if (ge_q) begin
					e_q <= e_q + div_quo;
				end else begin
					e_q <= e_q - div_quo - 32'(div_rem_nz);
				end
			end
		end
		if (cmd.div_start) begin
			ge_q <= (ram_rdata >= e_q);
		end
	end

	assign status        = status_q;
	assign measured      = meas_q;
	assign last_duration = last_q;
	assign estimate      = e_q;

endmodule

[sv/itwa_ctrl.sv]
module itwa_ctrl import itwa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  itwa_stat_t stat,
	output itwa_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	itwa_state_t state_q;
	itwa_state_t state_d;

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = stat.idx_bad ? ST_DONE : ST_LAST_RD;
			end
			ST_LAST_RD:   state_d = ST_LAST_WAIT;
			ST_LAST_WAIT: state_d = ST_ENT_RD;
			ST_ENT_RD:    state_d = ST_ENT_DIV;
			ST_ENT_DIV:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = stat.est_last ? ST_DONE : ST_ENT_RD;
				end
			end
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:     cmd.clr_step = 1'b1;
			ST_IDLE:      cmd.capture = start;
			ST_APPLY: begin
				cmd.apply       = !stat.idx_bad;
				cmd.zero_result = stat.idx_bad;
			end
			ST_LAST_RD:   cmd.rd_last = 1'b1;
			ST_LAST_WAIT: begin
				cmd.take_last = 1'b1;
				cmd.est_init  = 1'b1;
			end
			ST_ENT_RD:    cmd.rd_entry = 1'b1;
			ST_ENT_DIV:   cmd.div_start = 1'b1;
			ST_DIV_WAIT:  cmd.est_step = stat.div_done;
			default:      cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// The result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// An accepted word keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not start a sequence");

	// The estimate only advances on a finished division
	a_step_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.est_step |-> stat.div_done)
		else $error("estimate step without divider result");

	// The divider is started only with no read or write of the store pending
	a_div_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !(cmd.rd_entry || cmd.rd_last || cmd.apply || cmd.clr_step))
		else $error("divider start overlaps a store access");

endmodule

[sv/interval_timer_window_average.sv]
// Bank of interval timers with a windowed running-mean estimate.
// Command channel: drive kind, timer_index, duration_in and now_stamp with
// start high; the word is taken at a rising edge with start high and busy low.
// Each word gives one result on status, measured, last_duration and estimate,
// valid for exactly one cycle while done is high. The receiver cannot stall
// the block: it must take the result in that cycle.
// Sequence: an accepted word is applied, the last stored duration is read, and
// then the estimate walks the window of W entries, W being the window length;
// a new word is taken from the cycle after done. The walk does one store read
// and one 32-step shift-subtract division per window entry. A word with an
// out-of-range timer index gives an all-zero result, the sequence going from
// the apply state straight to the done state.
// Configuration: cfg_data (window length, clamped to 1..MAX_WINDOW) is
// written when cfg_valid is high; cfg_ready is always high. A write resets
// every ring position. Write only while the block is idle.
// Reset: arst_n clears the timers and starts a clearing pass over the sample
// store of TIMER_COUNT*MAX_WINDOW words (256 by default); busy stays high
// until the pass ends.
module interval_timer_window_average import itwa_pkg::*; #(
	parameter int TIMER_COUNT = 4,
	parameter int MAX_WINDOW  = 64,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [1:0]  timer_index,
	input  logic [31:0] duration_in,
	input  logic [31:0] now_stamp,
	output logic        done,
	output logic        status,
	output logic [31:0] measured,
	output logic [31:0] last_duration,
	output logic [31:0] estimate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	itwa_cmd_t  cmd;
	itwa_stat_t stat;

	// Take a configuration word in any cycle
	assign cfg_ready = 1'b1;

	itwa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	itwa_datapath #(
		.TIMER_COUNT (TIMER_COUNT),
		.MAX_WINDOW  (MAX_WINDOW),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (kind),
		.timer_index   (timer_index),
		.duration_in   (duration_in),
		.now_stamp     (now_stamp),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.status        (status),
		.measured      (measured),
		.last_duration (last_duration),
		.estimate      (estimate)
	);

endmodule

[sim/timer_result_checker.sv]
`timescale 1ns / 100ps

module timer_result_checker import itwa_pkg::*; #(
	parameter int TIMER_COUNT = 4,
	parameter int MAX_WINDOW  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [1:0]  timer_index,
	input  logic [31:0] duration_in,
	input  logic [31:0] now_stamp,
	input  logic        done,
	input  logic        status,
	input  logic [31:0] measured,
	input  logic [31:0] last_duration,
	input  logic [31:0] estimate,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          idle_stops
);

	typedef struct packed {
		logic        status;
		logic [31:0] measured;
		logic [31:0] last_duration;
		logic [31:0] estimate;
	} timer_reading_t;

	// Shadow copy of the timer bank
	logic [31:0] ring [TIMER_COUNT][MAX_WINDOW];
	int          wpos [TIMER_COUNT];
	logic        running [TIMER_COUNT];
	logic [31:0] stamp [TIMER_COUNT];
	int          window_len;

	timer_reading_t expected_readings [$];
	timer_reading_t want;
	timer_reading_t seen;
	int             mismatches;
	int             idle_stop_total;
	int             wlen;

	// Store one duration at the write position and advance it, wrapping at the window
	task automatic store_sample(input int t, input logic [31:0] x);
		ring[t][wpos[t]] = x;
		wpos[t] = (wpos[t] + 1 >= window_len) ? 0 : wpos[t] + 1;
	endtask

	// End a running interval: record now minus start, modulo 2^32
	task automatic close_interval(input int t, input logic [31:0] now, output logic [31:0] span);
		span = now - stamp[t];
		running[t] = 1'b0;
		store_sample(t, span);
	endtask

	// Apply one command word to the shadow bank and work out its result
	task automatic step_timer_bank(input logic [2:0] k, input int t, input logic [31:0] dur,
			input logic [31:0] now, output timer_reading_t r);
		longint unsigned mean;
		longint unsigned x;
		longint unsigned n;
		logic [31:0]     span;
		int              last_idx;
		r = '0;
		span = '0;
		case (k)
			KIND_RECORD: store_sample(t, dur);
			KIND_START: begin
				running[t] = 1'b1;
				stamp[t] = now;
			end
			KIND_STOP: begin
				if (running[t]) begin
					close_interval(t, now, span);
				end else begin
					r.status = 1'b1;
				end
			end
			KIND_LAP: begin
				if (running[t]) begin
					close_interval(t, now, span);
				end
				running[t] = 1'b1;
				stamp[t] = now;
			end
			default: ;
		endcase
		r.measured = span;
		last_idx = (wpos[t] == 0) ? window_len - 1 : wpos[t] - 1;
		r.last_duration = ring[t][last_idx];
		// Walk the window with floor steps toward each entry
		mean = 0;
		for (int i = 0; i < window_len; i++) begin
			x = 64'(ring[t][i]);
			n = 64'(i + 1);
			if (x >= mean) begin
				mean = mean + (x - mean) / n;
			end else begin
				mean = mean - ((mean - x) + n - 1) / n;
			end
		end
		r.estimate = mean[31:0];
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Clear the shadow bank and drop anything outstanding
			for (int t = 0; t < TIMER_COUNT; t++) begin
				for (int i = 0; i < MAX_WINDOW; i++) begin
					ring[t][i] = '0;
				end
				wpos[t] = 0;
				running[t] = 1'b0;
				stamp[t] = '0;
			end
			window_len = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;
			expected_readings.delete();
			mismatches = 0;
			idle_stop_total = 0;
			fail_count <= 0;
			pending <= 0;
			idle_stops <= 0;
		end else begin
			// Compare a strobed result against the oldest prediction
			if (done) begin
				if (expected_readings.size() == 0) begin
					$error("result strobed with no command outstanding");
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					seen = '{status, measured, last_duration, estimate};
					check_field("status", 32'(want.status), 32'(seen.status));
					check_field("measured", want.measured, seen.measured);
					check_field("last_duration", want.last_duration, seen.last_duration);
					check_field("estimate", want.estimate, seen.estimate);
				end
			end
			// Predict the result of an accepted command word
			if (start && !busy) begin
				step_timer_bank(kind, int'(timer_index), duration_in, now_stamp, want);
				expected_readings.push_back(want);
				if (want.status) begin
					idle_stop_total++;
				end
			end
			// Take a window length write: clamp it and rewind every ring
			if (cfg_valid && cfg_ready) begin
				wlen = int'(cfg_data);
				if (wlen < 1) begin
					wlen = 1;
				end else if (wlen > MAX_WINDOW) begin
					wlen = MAX_WINDOW;
				end
				window_len = wlen;
				for (int t = 0; t < TIMER_COUNT; t++) begin
					wpos[t] = 0;
				end
			end
			fail_count <= mismatches;
			pending <= expected_readings.size();
			idle_stops <= idle_stop_total;
		end
	end

endmodule

[sim/interval_timer_window_average_test.sv]
`timescale 1ns / 100ps

module interval_timer_window_average_test import itwa_pkg::*;;

	localparam int         QUIET_LIMIT = 20000;
	localparam int         TAIL_CYCLES = 400;
	localparam int         PHASES      = 11;
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [1:0]  timer_index;
	logic [31:0] duration_in;
	logic [31:0] now_stamp;
	logic        done;
	logic        status;
	logic [31:0] measured;
	logic [31:0] last_duration;
	logic [31:0] estimate;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	int fail_count;
	int pending;
	int idle_stops;

	// Window lengths per random phase: mostly short, a few at or past the maximum
	int window_plan [PHASES] = '{4, 1, 0, 2, 64, 127, 3, 7, 100, 16, 5};
	int item_plan [PHASES]   = '{40, 30, 15, 30, 8, 6, 30, 30, 6, 25, 30};

	logic [3:0]  timer_running;
	logic [31:0] clock_us;
	logic [2:0]  pick_kind;
	logic [1:0]  pick_timer;
	logic [31:0] pick_dur;
	int          roll;
	int          gap;
	bit          with_gaps;
	int          items_sent;
	int          quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	interval_timer_window_average u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.timer_index  (timer_index),
		.duration_in  (duration_in),
		.now_stamp    (now_stamp),
		.done         (done),
		.status       (status),
		.measured     (measured),
		.last_duration(last_duration),
		.estimate     (estimate),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	timer_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.timer_index  (timer_index),
		.duration_in  (duration_in),
		.now_stamp    (now_stamp),
		.done         (done),
		.status       (status),
		.measured     (measured),
		.last_duration(last_duration),
		.estimate     (estimate),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.idle_stops   (idle_stops)
	);

	// Present one command word after an idle gap and hold it until taken
	task automatic send_item(input logic [2:0] k, input logic [1:0] t, input logic [31:0] dur,
			input logic [31:0] now, input int idle);
		if (idle > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		timer_index <= t;
		duration_in <= dur;
		now_stamp <= now;
		do @(posedge clk); while (busy);
		items_sent++;
		// Track which timers run so that stops can be aimed at them
		case (k)
			KIND_START, KIND_LAP: timer_running[t] = 1'b1;
			KIND_STOP: timer_running[t] = 1'b0;
			default: ;
		endcase
	endtask

	task automatic drop_start();
		if (start) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Hold the sender until every outstanding result has been strobed
	task automatic pause_until_drained();
		drop_start();
		while (pending != 0) @(posedge clk);
	endtask

	// Write the window length on an idle block
	task automatic write_window(input logic [6:0] len);
		pause_until_drained();
		do @(posedge clk); while (busy);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop the run if no word moves on any channel for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no word accepted for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_READ;
		timer_index = '0;
		duration_in = '0;
		now_stamp = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		timer_running = '0;
		clock_us = '0;
		items_sent = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed commands at the reset window length
		send_item(KIND_READ, 2'd0, 32'd0, 32'd0, 0);
		send_item(KIND_STOP, 2'd1, 32'd0, 32'd5, 0);
		send_item(KIND_LAP, 2'd2, 32'd0, 32'd100, 3);
		send_item(KIND_RECORD, 2'd0, 32'hFFFF_FFFF, 32'd0, 0);
		send_item(KIND_RECORD, 2'd0, 32'd0, 32'd0, 0);
		send_item(KIND_RECORD, 2'd0, 32'd1, 32'd0, 50);
		send_item(KIND_RECORD, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(KIND_START, 2'd3, 32'd0, 32'hFFFF_FFF0, 0);
		send_item(KIND_STOP, 2'd3, 32'hFFFF_FFFF, 32'd16, 0);
		send_item(KIND_LAP, 2'd2, 32'd0, 32'd350, 0);
		send_item(KIND_LAP, 2'd2, 32'd0, 32'd350, 1);
		send_item(KIND_SPARE_FIRST, 2'd1, 32'd77, 32'd9, 0);
		send_item(KIND_SPARE_FIRST + 3'd1, 2'd2, 32'd0, 32'd0, 0);
		send_item(KIND_SPARE_LAST, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_item(KIND_START, 2'd1, 32'd0, 32'd0, 0);
		send_item(KIND_STOP, 2'd1, 32'd0, 32'hFFFF_FFFF, 0);
		send_item(KIND_STOP, 2'd1, 32'd0, 32'hFFFF_FFFF, 0);
		send_item(KIND_START, 2'd0, 32'd0, 32'd12345, 2);
		pause_until_drained();
		send_item(KIND_LAP, 2'd0, 32'd0, 32'd12352, 0);
		send_item(KIND_READ, 2'd3, 32'd0, 32'd0, 0);

		// Random phases, one window length each
		for (int p = 0; p < PHASES; p++) begin
			write_window(7'(window_plan[p]));
			with_gaps = (p % 3) != 2;
			for (int i = 0; i < item_plan[p]; i++) begin
				roll = $urandom_range(0, 99);
				pick_timer = 2'($urandom_range(0, 3));
				if (roll < 30) begin
					pick_kind = KIND_RECORD;
				end else if (roll < 50) begin
					pick_kind = KIND_START;
				end else if (roll < 70) begin
					pick_kind = KIND_STOP;
					// Aim most stops at a running timer
					if (timer_running != 0 && $urandom_range(0, 4) != 0) begin
						while (!timer_running[pick_timer]) pick_timer = 2'($urandom_range(0, 3));
					end
				end else if (roll < 85) begin
					pick_kind = KIND_LAP;
				end else if (roll < 95) begin
					pick_kind = KIND_READ;
				end else begin
					pick_kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
				end
				roll = $urandom_range(0, 7);
				if (roll == 0) begin
					pick_dur = '0;
				end else if (roll == 1) begin
					pick_dur = '1;
				end else if (roll < 4) begin
					pick_dur = $urandom_range(0, 1000);
				end else begin
					pick_dur = $urandom;
				end
				// Advance time, with rare jumps that force wrap-around and long spans
				if ($urandom_range(0, 15) == 0) begin
					clock_us = $urandom;
				end else begin
					clock_us = clock_us + $urandom_range(0, 5000);
				end
				gap = 0;
				if (with_gaps) begin
					roll = $urandom_range(0, 19);
					if (roll < 12) begin
						gap = 0;
					end else if (roll < 18) begin
						gap = $urandom_range(1, 4);
					end else if (roll == 18) begin
						gap = $urandom_range(5, 40);
					end else begin
						gap = $urandom_range(41, 120);
					end
				end
				if ($urandom_range(0, 24) == 0) begin
					pause_until_drained();
				end
				send_item(pick_kind, pick_timer, pick_dur, clock_us, gap);
			end
		end

		// Drain, then watch a while for stray strobes
		drop_start();
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run: %0d commands over %0d window lengths, clamped writes of 0 and above 64 included",
			items_sent, PHASES + 1);
		$display("Run: every command kind and spare code driven, %0d stops on idle timers flagged",
			idle_stops);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
